// ===== design/sgt_pkg.sv =====
// shared types and constants for the shake gesture toggle detector
// no dependencies; imported by every design module

package sgt_pkg;

  localparam int AxisW  = 16;
  localparam int TimeW  = 32;
  localparam int LevelW = 16;
  localparam int SqW    = 31;
  localparam int SumW   = 32;
  localparam int MagW   = 16;
  localparam int GravW  = 32;
  localparam int ProdW  = 48;

  localparam int AddrW  = 5;
  localparam int DataW  = 32;
  localparam int InTdW  = 96;
  localparam int OutTdW = 24;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_REVERSALS = 3'd1;
  localparam logic [2:0] REG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_COOLDOWN  = 3'd3;
  localparam logic [2:0] REG_ALPHA     = 3'd4;

  localparam logic [15:0] THRESHOLD_RST = 16'd6000;
  localparam logic [3:0]  REVERSALS_RST = 4'd3;
  localparam logic [15:0] WINDOW_RST    = 16'd800;
  localparam logic [15:0] COOLDOWN_RST  = 16'd1500;
  localparam logic [15:0] ALPHA_RST     = 16'd655;

  // one g in q16.16
  localparam logic [GravW-1:0] GRAVITY_RST = 32'h4000_0000;

  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  localparam logic [3:0] TOTAL_MAX = 4'd15;

  typedef struct packed {
    logic [15:0] shake_threshold;
    logic [3:0]  reversals_needed;
    logic [15:0] window_ms;
    logic [15:0] cooldown_ms;
    logic [15:0] ema_alpha;
  } cfg_t;

  typedef struct packed {
    logic mic_on;
    logic toggled;
  } gres_t;

endpackage

// ===== design/sgt_sq_lane.sv =====
// one axis lane: registered square of a signed 16-bit sample
// depends on sgt_pkg

module sgt_sq_lane
  import sgt_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AxisW-1:0] a,
  output logic        [SqW-1:0]   sq
);

  logic signed [2*AxisW-1:0] prod;

  assign prod = a * a;

  // square is at most 2^30, so the low 31 bits hold it
  always_ff @(posedge clk) begin
    if (en) begin
      sq <= prod[SqW-1:0];
    end
  end

endmodule

// ===== design/sgt_isqrt.sv =====
// iterative floor square root of a 32-bit value, one result bit per step
// depends on sgt_pkg

module sgt_isqrt
  import sgt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SumW-1:0] op,
  output logic            done,
  output logic [MagW-1:0] root
);

  logic            busy;
  logic [SumW-1:0] rem;
  logic [SumW-1:0] res;
  logic [SumW-1:0] bitv;
  logic [SumW:0]   trial;
  logic            take;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign take  = {1'b0, rem} >= trial;
  assign root  = res[MagW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= op;
      res  <= '0;
      bitv <= {2'b01, {(SumW-2){1'b0}}};
    end else if (busy) begin
      if (take) begin
        rem <= rem - trial[SumW-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== design/sgt_gesture.sv =====
// gravity average, swing detection and reversal counting for one sample
// depends on sgt_pkg

module sgt_gesture
  import sgt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             start,
  input  logic [MagW-1:0]  mag,
  input  logic [TimeW-1:0] now,
  output logic             done,
  output gres_t            res
);

  logic [4:0]       stg;
  logic [MagW-1:0]  mag_r;
  logic [TimeW-1:0] now_r;

  logic [GravW-1:0] gravity;
  logic [1:0]       last_sign;
  logic [3:0]       total;
  logic [TimeW-1:0] first_time;
  logic [TimeW-1:0] cd_until;
  logic             mic_flag;

  logic [GravW:0]   diff;
  logic             diff_neg;
  logic [GravW-1:0] diff_abs;
  logic             neg_r;
  logic [GravW-1:0] abs_r;
  logic [ProdW-1:0] prod_r;
  logic [GravW-1:0] step_dn;
  logic             swing_r;
  logic             pos_r;

  logic [TimeW-1:0] since_cd;
  logic [TimeW-1:0] win_diff;
  logic [TimeW-1:0] win_post;
  logic             live;
  logic [1:0]       sign_now;
  logic [3:0]       total_inc;
  logic [TimeW-1:0] tog_diff;
  logic             toggle;
  logic [1:0]       last_sign_next;
  logic [3:0]       total_next;
  logic [TimeW-1:0] first_time_next;
  logic [TimeW-1:0] cd_until_next;
  logic             mic_flag_next;

  // signed q16.16 difference of magnitude and gravity, used before and after the update
  assign diff     = {1'b0, mag_r, 16'h0000} - {1'b0, gravity};
  assign diff_neg = diff[GravW];
  assign diff_abs = diff_neg ? (~diff[GravW-1:0] + 1'b1) : diff[GravW-1:0];

  // downward step rounds toward minus infinity
  assign step_dn = prod_r[ProdW-1:16] + {31'd0, |prod_r[15:0]};

  assign since_cd = now_r - cd_until;
  assign win_diff = now_r - first_time;
  assign live     = (since_cd != '0) && !since_cd[TimeW-1];
  assign sign_now = pos_r ? SIGN_POS : SIGN_NEG;
  assign total_inc = (total == TOTAL_MAX) ? TOTAL_MAX : total + 4'd1;
  assign tog_diff = (total == 4'd0) ? '0 : win_diff;
  assign win_post = now_r - first_time_next;

  always_comb begin
    toggle          = 1'b0;
    last_sign_next  = last_sign;
    total_next      = total;
    first_time_next = first_time;
    cd_until_next   = cd_until;
    mic_flag_next   = mic_flag;
    if (live && swing_r) begin
      if (sign_now != last_sign && last_sign != SIGN_NONE) begin
        if (total == 4'd0) begin
          first_time_next = now_r;
        end
        if (total_inc >= cfg.reversals_needed && tog_diff < {16'd0, cfg.window_ms}) begin
          toggle        = 1'b1;
          mic_flag_next = ~mic_flag;
          cd_until_next = now_r + {16'd0, cfg.cooldown_ms};
          total_next    = 4'd0;
        end else begin
          total_next = total_inc;
        end
      end
      last_sign_next = sign_now;
    end
    // stale count
    if (total_next != 4'd0 && win_post > {16'd0, cfg.window_ms}) begin
      total_next     = 4'd0;
      last_sign_next = SIGN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
      done <= 1'b0;
    end else begin
      stg  <= {stg[3:0], start};
      done <= stg[4];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      now_r <= now;
    end
    if (stg[0]) begin
      neg_r <= diff_neg;
      abs_r <= diff_abs;
    end
    if (stg[1]) begin
      prod_r <= cfg.ema_alpha * abs_r;
    end
    if (stg[3]) begin
      swing_r <= diff_abs > {cfg.shake_threshold, 16'h0000};
      pos_r   <= !diff_neg && (diff != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity    <= GRAVITY_RST;
      last_sign  <= SIGN_NONE;
      total      <= '0;
      first_time <= '0;
      cd_until   <= '0;
      mic_flag   <= 1'b1;
      res        <= '0;
    end else begin
      if (stg[2]) begin
        gravity <= neg_r ? gravity - step_dn : gravity + prod_r[ProdW-1:16];
      end
      if (stg[4]) begin
        last_sign   <= last_sign_next;
        total       <= total_next;
        first_time  <= first_time_next;
        cd_until    <= cd_until_next;
        mic_flag    <= mic_flag_next;
        res.mic_on  <= mic_flag_next;
        res.toggled <= toggle;
      end
    end
  end

endmodule

// ===== design/shake_gesture_toggle_detector.sv =====
// shake gesture toggle detector top level: stream ports, register port, sequencing
// depends on sgt_pkg, sgt_sq_lane, sgt_isqrt, sgt_gesture
//
// an accepted input transaction passes through the squaring lanes, the lane sum, the
// 16-step square root unit and the gesture pipeline, one sample at a time, to m_tvalid;
// a new sample is taken while the previous result still waits on the output
// reset (rst, synchronous) restores register defaults, gravity to one g, mic enabled

module shake_gesture_toggle_detector
  import sgt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // accel_x, accel_y, accel_z, time_ms, audio_level from bit 0 up
  input  logic [InTdW-1:0]  s_tdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  // mic_on, toggled, audio_out, zero pad from bit 0 up
  output logic [OutTdW-1:0] m_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_GEST  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  cfg_t cfg;

  logic signed [AxisW-1:0] ax, ay, az;
  logic [TimeW-1:0]  time_r;
  logic [LevelW-1:0] audio_r;
  logic [SqW-1:0]    sq_x, sq_y, sq_z;
  logic [SumW-1:0]   sum_r;
  logic              root_done;
  logic [MagW-1:0]   root;
  logic              gest_done;
  gres_t             gres;
  logic              out_free;
  logic              out_load;

  logic              out_mic;
  logic              out_tog;
  logic [LevelW-1:0] out_audio;

  logic              wr_en;
  logic [2:0]        reg_idx;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_OUT) && out_free;

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shake_threshold  <= THRESHOLD_RST;
      cfg.reversals_needed <= REVERSALS_RST;
      cfg.window_ms        <= WINDOW_RST;
      cfg.cooldown_ms      <= COOLDOWN_RST;
      cfg.ema_alpha        <= ALPHA_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg.shake_threshold  <= pwdata[15:0];
        REG_REVERSALS: cfg.reversals_needed <= pwdata[3:0];
        REG_WINDOW:    cfg.window_ms        <= pwdata[15:0];
        REG_COOLDOWN:  cfg.cooldown_ms      <= pwdata[15:0];
        REG_ALPHA:     cfg.ema_alpha        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = {16'd0, cfg.shake_threshold};
      REG_REVERSALS: prdata = {28'd0, cfg.reversals_needed};
      REG_WINDOW:    prdata = {16'd0, cfg.window_ms};
      REG_COOLDOWN:  prdata = {16'd0, cfg.cooldown_ms};
      REG_ALPHA:     prdata = {16'd0, cfg.ema_alpha};
      default:       prdata = '0;
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ax      <= s_tdata[15:0];
      ay      <= s_tdata[31:16];
      az      <= s_tdata[47:32];
      time_r  <= s_tdata[79:48];
      audio_r <= s_tdata[95:80];
    end
  end

  sgt_sq_lane u_lane_x (.clk(clk), .en(state == S_SQ), .a(ax), .sq(sq_x));
  sgt_sq_lane u_lane_y (.clk(clk), .en(state == S_SQ), .a(ay), .sq(sq_y));
  sgt_sq_lane u_lane_z (.clk(clk), .en(state == S_SQ), .a(az), .sq(sq_z));

  // merge the lanes: sum of squares is below 2^32
  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      sum_r <= {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
    end
  end

  sgt_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_START),
    .op   (sum_r),
    .done (root_done),
    .root (root)
  );

  sgt_gesture u_gesture (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .start(root_done),
    .mag  (root),
    .now  (time_r),
    .done (gest_done),
    .res  (gres)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_SQ;
      S_SQ:    state_next = S_SUM;
      S_SUM:   state_next = S_START;
      S_START: state_next = S_ROOT;
      S_ROOT:  if (root_done) state_next = S_GEST;
      S_GEST:  if (gest_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mic   <= gres.mic_on;
      out_tog   <= gres.toggled;
      out_audio <= gres.mic_on ? audio_r : '0;
    end
  end

  assign m_tdata = {6'd0, out_audio, out_tog, out_mic};

endmodule

// ===== design/sgt_checker.sv =====
// port-level checks for the shake gesture toggle detector, bound to the top level
// depends on sgt_pkg and shake_gesture_toggle_detector

module sgt_checker
  import sgt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OutTdW-1:0] m_tdata
);

  // audio is muted whenever the mic flag is off
  a_muted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[17:2] == 16'd0)
    else $error("audio passed while mic off");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:18] == 6'd0)
    else $error("nonzero pad bits on output");

  // one sample in flight: intake closes right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in progress");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

endmodule

bind shake_gesture_toggle_detector sgt_checker u_sgt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ===== test/mic_toggle_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the shake gesture toggle detector: tracks register writes, predicts each
// result from the accepted samples and compares the output stream; depends on sgt_pkg

module mic_toggle_checker
  import sgt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [InTdW-1:0]  s_tdata,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [OutTdW-1:0] m_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  input  logic [DataW-1:0]  prdata,
  input  logic              pready,
  output int                failures,
  output int                outstanding
);

  typedef struct packed {
    logic              mic_on;
    logic              toggled;
    logic [LevelW-1:0] audio_out;
  } mic_out_t;

  cfg_t             settings;
  logic [GravW-1:0] gravity_q16;
  logic [1:0]       swing_dir;
  logic [3:0]       reversal_cnt;
  logic [TimeW-1:0] window_open_ms;
  logic [TimeW-1:0] quiet_until_ms;
  logic             mic_enabled;
  mic_out_t         mic_outputs_due[$];
  int               mismatch_cnt = 0;

  assign failures = mismatch_cnt;

  function automatic longint floor_sqrt(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // advances the gesture state by one sample and returns the outputs it should produce
  function automatic mic_out_t track_shake(input logic [InTdW-1:0] smp);
    longint           ax;
    longint           ay;
    longint           az;
    longint           mag_q;
    longint           diff;
    longint           delta;
    longint           dyn;
    longint           adyn;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] since_quiet;
    logic [TimeW-1:0] span;
    logic [1:0]       dir;
    mic_out_t         res;
    ax    = longint'($signed(smp[15:0]));
    ay    = longint'($signed(smp[31:16]));
    az    = longint'($signed(smp[47:32]));
    now   = smp[79:48];
    res.toggled = 1'b0;
    mag_q = floor_sqrt(ax * ax + ay * ay + az * az) << 16;

    // moving average with the step rounded toward minus infinity
    diff = mag_q - longint'(gravity_q16);
    if (diff >= 0) begin
      delta = (longint'(settings.ema_alpha) * diff) >> 16;
    end else begin
      delta = -((longint'(settings.ema_alpha) * (-diff) + 65535) >> 16);
    end
    gravity_q16 = 32'(longint'(gravity_q16) + delta);
    dyn  = mag_q - longint'(gravity_q16);
    adyn = (dyn < 0) ? -dyn : dyn;

    since_quiet = now - quiet_until_ms;
    if (since_quiet != '0 && !since_quiet[TimeW-1]) begin
      if (adyn > longint'(settings.shake_threshold) * 65536) begin
        dir = (dyn > 0) ? SIGN_POS : SIGN_NEG;
        if (dir != swing_dir && swing_dir != SIGN_NONE) begin
          if (reversal_cnt == 4'd0) window_open_ms = now;
          if (reversal_cnt < TOTAL_MAX) reversal_cnt = reversal_cnt + 4'd1;
          span = now - window_open_ms;
          if (reversal_cnt >= settings.reversals_needed &&
              span < {16'd0, settings.window_ms}) begin
            mic_enabled    = ~mic_enabled;
            res.toggled    = 1'b1;
            quiet_until_ms = now + {16'd0, settings.cooldown_ms};
            reversal_cnt   = 4'd0;
          end
        end
        swing_dir = dir;
      end
    end
    span = now - window_open_ms;
    if (reversal_cnt != 4'd0 && span > {16'd0, settings.window_ms}) begin
      reversal_cnt = 4'd0;
      swing_dir    = SIGN_NONE;
    end

    res.mic_on    = mic_enabled;
    res.audio_out = mic_enabled ? smp[95:80] : '0;
    return res;
  endfunction

  always @(posedge clk) begin : observe
    mic_out_t         due;
    logic [DataW-1:0] reg_now;
    bit               known;
    if (rst) begin
      settings.shake_threshold  = THRESHOLD_RST;
      settings.reversals_needed = REVERSALS_RST;
      settings.window_ms        = WINDOW_RST;
      settings.cooldown_ms      = COOLDOWN_RST;
      settings.ema_alpha        = ALPHA_RST;
      gravity_q16    = GRAVITY_RST;
      swing_dir      = SIGN_NONE;
      reversal_cnt   = 4'd0;
      window_open_ms = '0;
      quiet_until_ms = '0;
      mic_enabled    = 1'b1;
      mic_outputs_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (mic_outputs_due.size() == 0) begin
          $error("result transaction with no sample waiting: mic_on %0d toggled %0d audio_out %0d",
                 m_tdata[0], m_tdata[1], m_tdata[17:2]);
          mismatch_cnt++;
        end else begin
          due = mic_outputs_due.pop_front();
          if (m_tdata[0] !== due.mic_on) begin
            $error("mic_on: expected %0d, got %0d", due.mic_on, m_tdata[0]);
            mismatch_cnt++;
          end
          if (m_tdata[1] !== due.toggled) begin
            $error("toggled: expected %0d, got %0d", due.toggled, m_tdata[1]);
            mismatch_cnt++;
          end
          if (m_tdata[17:2] !== due.audio_out) begin
            $error("audio_out: expected %0d, got %0d", due.audio_out, m_tdata[17:2]);
            mismatch_cnt++;
          end
        end
      end

      if (s_tvalid && s_tready) mic_outputs_due.push_back(track_shake(s_tdata));

      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[AddrW-1:2])
            REG_THRESHOLD: settings.shake_threshold  = pwdata[15:0];
            REG_REVERSALS: settings.reversals_needed = pwdata[3:0];
            REG_WINDOW:    settings.window_ms        = pwdata[15:0];
            REG_COOLDOWN:  settings.cooldown_ms      = pwdata[15:0];
            REG_ALPHA:     settings.ema_alpha        = pwdata[15:0];
            default: ;
          endcase
        end else begin
          known = 1'b1;
          case (paddr[AddrW-1:2])
            REG_THRESHOLD: reg_now = {16'd0, settings.shake_threshold};
            REG_REVERSALS: reg_now = {28'd0, settings.reversals_needed};
            REG_WINDOW:    reg_now = {16'd0, settings.window_ms};
            REG_COOLDOWN:  reg_now = {16'd0, settings.cooldown_ms};
            REG_ALPHA:     reg_now = {16'd0, settings.ema_alpha};
            default: begin
              known   = 1'b0;
              reg_now = '0;
            end
          endcase
          if (known && prdata !== reg_now) begin
            $error("prdata at 0x%0h: expected %0d, got %0d", paddr, reg_now, prdata);
            mismatch_cnt++;
          end
        end
      end
    end
    outstanding <= mic_outputs_due.size();
  end

endmodule

// ===== test/shake_gesture_toggle_detector_tb.sv =====
`timescale 1ns / 1ps
// top of the shake gesture toggle detector testbench: clock, reset, sample and register
// traffic, random output stalls and the verdict; depends on sgt_pkg and mic_toggle_checker

module shake_gesture_toggle_detector_tb;
  import sgt_pkg::*;

  localparam int         StallLimit = 2000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic              clk = 1'b0;
  logic              rst;
  logic [InTdW-1:0]  s_tdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [OutTdW-1:0] m_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  int                failures;
  int                outstanding;
  int                stall_cycles = 0;
  bit                steady = 1'b0;   // no idling on either side
  logic [TimeW-1:0]  now_ms;          // timestamp cursor for well-formed traffic

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shake_gesture_toggle_detector DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mic_toggle_checker mic_check (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic logic [15:0] axis_reading(input int lo, input int hi);
    int v;
    v = $urandom_range(lo, hi);
    return 16'($urandom_range(0, 1) ? -v : v);
  endfunction

  task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [31:0] t,
                             input logic [15:0] lvl);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {lvl, t, az, ay, ax};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] idx,
                            input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits of each write carry junk that the register must drop
  task automatic apply_settings(input logic [15:0] thr, input logic [3:0] need,
                                input logic [15:0] win, input logic [15:0] cool,
                                input logic [15:0] alpha);
    reg_access(1'b1, REG_THRESHOLD, {16'($urandom), thr});
    reg_access(1'b0, REG_THRESHOLD, '0);
    reg_access(1'b1, REG_REVERSALS, {28'($urandom), need});
    reg_access(1'b0, REG_REVERSALS, '0);
    reg_access(1'b1, REG_WINDOW, {16'($urandom), win});
    reg_access(1'b0, REG_WINDOW, '0);
    reg_access(1'b1, REG_COOLDOWN, {16'($urandom), cool});
    reg_access(1'b0, REG_COOLDOWN, '0);
    reg_access(1'b1, REG_ALPHA, {16'($urandom), alpha});
    reg_access(1'b0, REG_ALPHA, '0);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // swing bursts of alternating hard and light samples, rest periods, time leaps and noise
  task automatic shake_traffic(input int n_items, input int zero_step_pct);
    int  sent;
    int  kind;
    int  len;
    int  step;
    int  r;
    int  level;
    bit  hard;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(3, 20);
        r   = $urandom_range(0, 99);
        if (r < zero_step_pct) step = 0;
        else if (r < 60) step = $urandom_range(10, 60);
        else if (r < 90) step = $urandom_range(60, 300);
        else step = $urandom_range(300, 1500);
        hard  = $urandom_range(0, 1);
        level = $urandom_range(12000, 32767);
        repeat (len) begin
          if (hard) begin
            send_sample(axis_reading(level - 4000, level), axis_reading(level - 4000, level),
                        axis_reading(level - 4000, level), now_ms, 16'($urandom));
          end else begin
            send_sample(axis_reading(0, 3000), axis_reading(0, 3000), axis_reading(0, 3000),
                        now_ms, 16'($urandom));
          end
          now_ms += step;
          // an occasional repeated direction breaks the alternation
          if ($urandom_range(0, 9) != 0) hard = !hard;
          sent++;
        end
        now_ms += $urandom_range(0, 3000);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6)) begin
          send_sample(axis_reading(0, 800), axis_reading(0, 800), axis_reading(15600, 17200),
                      now_ms, 16'($urandom));
          now_ms += 40;
          sent++;
        end
      end else if (kind < 88) begin
        now_ms += $urandom_range(1 << 28, 1 << 30);
      end else begin
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
        sent++;
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!steady) begin : stall
        int gap;
        gap = idle_len();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    now_ms   = 32'd5200;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values read back
    reg_access(1'b0, REG_THRESHOLD, '0);
    reg_access(1'b0, REG_REVERSALS, '0);
    reg_access(1'b0, REG_WINDOW, '0);
    reg_access(1'b0, REG_COOLDOWN, '0);
    reg_access(1'b0, REG_ALPHA, '0);

    // time equal to the cooldown end, then one just before it across the wrap
    send_sample(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'hFFFF);
    send_sample(16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd1, 16'd1234);
    send_sample(16'd0, 16'd0, 16'd16384, 32'd41, 16'd500);
    // three reversals inside the window turn the mic off
    send_sample(16'd20000, 16'd20000, 16'd20000, 32'd1000, 16'd700);
    send_sample(16'd100, -16'sd100, 16'd50, 32'd1040, 16'd701);
    send_sample(16'd20000, -16'sd20000, 16'd20000, 32'd1080, 16'd702);
    send_sample(-16'sd80, 16'd60, 16'd0, 32'd1120, 16'd703);
    // swings during cooldown and at its last millisecond are ignored
    send_sample(16'd20000, 16'd20000, 16'd20000, 32'd1160, 16'd704);
    send_sample(16'd20000, 16'd20000, 16'd20000, 32'd2620, 16'd705);
    send_sample(16'd20000, 16'd20000, 16'd20000, 32'd2621, 16'd706);
    // reversal too late for the window: the count goes stale
    send_sample(16'd10, 16'd10, 16'd10, 32'd3500, 16'd707);
    send_sample(16'd20000, 16'd20000, 16'd20000, 32'd5000, 16'd708);
    send_sample(16'd10, 16'd10, 16'd10, 32'd5040, 16'd709);
    send_sample(16'd20000, 16'd20000, 16'd20000, 32'd5080, 16'd710);
    send_sample(16'd10, 16'd10, 16'd10, 32'd5120, 16'd711);
    send_sample(16'd0, 16'd0, 16'd16384, 32'd5160, 16'hFFFF);
    s_tvalid <= 1'b0;
    wait_drained();

    apply_settings(16'd6000, 4'd3, 16'd800, 16'd1500, 16'd655);
    shake_traffic(70, 10);
    wait_drained();
    apply_settings(16'd0, 4'd1, 16'hFFFF, 16'd0, 16'hFFFF);
    shake_traffic(70, 10);
    wait_drained();
    apply_settings(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF, 16'd1);
    shake_traffic(70, 10);
    wait_drained();
    steady = 1'b1;
    // zero window with frozen timestamps lets the reversal count saturate
    apply_settings(16'd3000, 4'd15, 16'd0, 16'd200, 16'd1000);
    shake_traffic(70, 60);
    wait_drained();
    steady = 1'b0;
    apply_settings(16'd8000, 4'd0, 16'd2000, 16'd100, 16'd0);
    shake_traffic(70, 10);
    wait_drained();
    apply_settings(16'($urandom_range(0, 20000)), 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                   16'($urandom));
    reg_access(1'b1, REG_UNUSED, $urandom);
    reg_access(1'b0, REG_UNUSED, '0);
    shake_traffic(70, 10);
    wait_drained();
    steady = 1'b1;
    apply_settings(16'd6000, 4'd3, 16'd800, 16'd1500, 16'd655);
    shake_traffic(70, 10);
    wait_drained();

    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sgt_pkg.sv
design/sgt_sq_lane.sv
design/sgt_isqrt.sv
design/sgt_gesture.sv
design/shake_gesture_toggle_detector.sv
design/sgt_checker.sv
test/mic_toggle_checker.sv
test/shake_gesture_toggle_detector_tb.sv
